// ----- hw/rtl/hafe_pkg.sv -----
// ----------------------------------------------------------------------------
// hafe_pkg
// Shared types, constants and character helpers for the hex/ASCII frame
// encoder.
// ----------------------------------------------------------------------------
package hafe_pkg;

  localparam int unsigned MaxChars = 4;
  localparam int unsigned CountW   = $clog2(MaxChars + 1);

  localparam logic [6:0] Mask7     = 7'h7F;
  localparam logic [7:0] ParityBit = 8'h80;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] LetterA   = 8'h41;

  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } char_t;

  // Upper-case ASCII hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nibble);
    logic [7:0] ext;
    ext = {4'h0, nibble};
    if (nibble < 4'd10) begin
      return DigitZero + ext;
    end
    return LetterA + (ext - 8'd10);
  endfunction

  // Keep the low seven bits; bit 7 is set when the eight bits XOR to zero.
  function automatic logic [7:0] with_parity(input logic [7:0] c);
    logic [7:0] res;
    res = {1'b0, c[6:0] & Mask7};
    if (!(^c)) begin
      res = res | ParityBit;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/hex_ascii_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// hex_ascii_frame_encoder
// Turns command and data bytes into framed characters with an XOR checksum
// and parity.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_valid_i/in_ready_o channel. An item with
// starts_frame_i set carries the command byte and samples encode_hex_i for
// the frame; later items carry one data byte each, sent as two hex digits in
// hex mode or as one character in raw mode. An item with ends_frame_i set is
// followed by two hex checksum characters, the second flagged by frame_end_o.
// Characters leave one per cycle on the out_valid_o/out_ready_i channel
// while out_ready_i is high. The first character of an item is valid the
// cycle after its transfer. An item produces one to four characters, held
// in the four-entry character buffer that feeds the single output byte. The
// next item is taken in the same cycle the last buffered character leaves,
// so the output stays busy every cycle while items are offered.
// Reset clears the checksum, the mode and the character count, not the
// buffer contents. When the receiver stalls, the current character
// holds and input transfers wait.
// ----------------------------------------------------------------------------
module hex_ascii_frame_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       starts_frame_i,
  input  logic       ends_frame_i,
  input  logic       encode_hex_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o
);
  import hafe_pkg::*;

  logic [6:0] xor_q, xor_d;
  logic       hex_mode_q, hex_mode_d;
  count_t     count_q, count_d;
  char_t      buf_q [MaxChars];
  char_t      buf_d [MaxChars];

  logic       in_xfer, out_xfer;
  logic       two_chars;
  logic [7:0] c0, c1, ck0, ck1;
  logic [6:0] xor_after;

  assign out_valid_o = (count_q != '0);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign in_ready_o  = (count_q == '0) || ((count_q == count_t'(1)) && out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_byte_o  = buf_q[0].out_byte;
  assign frame_end_o = buf_q[0].frame_end;

  // Characters of the incoming item, before parity.
  always_comb begin
    two_chars  = !starts_frame_i && hex_mode_q;
    hex_mode_d = starts_frame_i ? encode_hex_i : hex_mode_q;
    if (starts_frame_i) begin
      c0        = byte_value_i;
      c1        = byte_value_i;
      xor_after = byte_value_i[6:0];
    end else if (hex_mode_q) begin
      c0        = hex_char(byte_value_i[7:4]);
      c1        = hex_char(byte_value_i[3:0]);
      xor_after = xor_q ^ c0[6:0] ^ c1[6:0];
    end else begin
      c0        = byte_value_i;
      c1        = byte_value_i;
      xor_after = xor_q ^ byte_value_i[6:0];
    end
    ck0   = hex_char({1'b0, xor_after[6:4]});
    ck1   = hex_char(xor_after[3:0]);
    xor_d = ends_frame_i ? 7'h00 : xor_after;
  end

  // Buffer load on an input transfer, otherwise shift out on an output one.
  always_comb begin
    buf_d   = buf_q;
    count_d = count_q;
    if (in_xfer) begin
      buf_d[0] = '{out_byte: with_parity(c0), frame_end: 1'b0};
      if (two_chars) begin
        buf_d[1] = '{out_byte: with_parity(c1),  frame_end: 1'b0};
        buf_d[2] = '{out_byte: with_parity(ck0), frame_end: 1'b0};
        buf_d[3] = '{out_byte: with_parity(ck1), frame_end: 1'b1};
      end else begin
        buf_d[1] = '{out_byte: with_parity(ck0), frame_end: 1'b0};
        buf_d[2] = '{out_byte: with_parity(ck1), frame_end: 1'b1};
        buf_d[3] = '{out_byte: with_parity(ck1), frame_end: 1'b1};
      end
      count_d = count_t'(two_chars ? 2 : 1) + (ends_frame_i ? count_t'(2) : count_t'(0));
    end else if (out_xfer) begin
      for (int i = 0; i < MaxChars - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      count_d = count_q - count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q      <= '0;
      hex_mode_q <= 1'b0;
      count_q    <= '0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        xor_q      <= xor_d;
        hex_mode_q <= hex_mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // Checks.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(MaxChars))
    else $error("character count out of range");

  a_end_clears_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && ends_frame_i) |=> (xor_q == 7'h00))
    else $error("checksum not cleared after frame end");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (count_q == count_t'(1)))
    else $error("frame end flagged before the last buffered character");

  a_cmd_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && starts_frame_i) |=>
      (out_valid_o && (out_byte_o[6:0] == $past(byte_value_i[6:0]))))
    else $error("command character not presented first");

endmodule
